@@ src/ssb_pkg.sv @@
package ssb_pkg;

  localparam int MAX_SPRITES       = 32;
  localparam int VERTS_PER_SPRITE  = 6;
  localparam int IDX_W             = $clog2(MAX_SPRITES);
  localparam int CNT_W             = $clog2(MAX_SPRITES + 1);
  localparam int TEX_W             = 32;
  localparam int DEPTH_W           = 16;
  localparam int SRC_W             = 5;
  localparam int OFS_W             = 8;
  localparam int MODE_W            = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_NONE       = 2'd0,
    MODE_DEPTH_UP   = 2'd1,
    MODE_DEPTH_DOWN = 2'd2,
    MODE_TEX_UP     = 2'd3
  } sort_mode_e;

  typedef struct packed {
    logic [TEX_W-1:0]   tex;
    logic [DEPTH_W-1:0] depth;
  } entry_t;

  typedef struct packed {
    logic [SRC_W-1:0] source_index;
    logic [TEX_W-1:0] texture_out;
    logic             starts_run;
    logic             ends_run;
    logic [OFS_W-1:0] run_offset;
    logic [OFS_W-1:0] run_vertices;
    logic             overflow;
    logic             last_out;
  } out_item_t;

  typedef struct packed {
    logic store;
    logic clr_batch;
    logic rank_fetch;
    logic rank_start;
    logic rank_step;
    logic out_init;
    logic ord_rd;
    logic dat_rd;
    logic latch;
    logic emit;
  } ssb_cmd_t;

  typedef struct packed {
    logic j_last;
    logic i_last;
    logic cur_empty;
    logic more_after;
    logic more_fetch;
    logic k_last;
    logic out_free;
  } ssb_status_t;

  // Unsigned key whose ascending order matches the requested sort order.
  function automatic logic [TEX_W-1:0] sort_key(sort_mode_e m, logic [TEX_W-1:0] tex,
                                               logic [DEPTH_W-1:0] d);
    logic [DEPTH_W-1:0] biased;
    logic [TEX_W-1:0]   key;
    biased = {~d[DEPTH_W-1], d[DEPTH_W-2:0]};
    case (m)
      MODE_DEPTH_UP:   key = TEX_W'(biased);
      MODE_DEPTH_DOWN: key = TEX_W'(~biased);
      MODE_TEX_UP:     key = tex;
      default:         key = '0;
    endcase
    return key;
  endfunction

  function automatic logic [OFS_W-1:0] vert_count(logic [CNT_W-1:0] x);
    logic [15:0] p;
    p = 16'(x) * 16'(VERTS_PER_SPRITE);
    return p[OFS_W-1:0];
  endfunction

endpackage

@@ src/ssb_if.sv @@
interface ssb_sprite_if;
  logic                                valid;
  logic                                ready;
  logic [ssb_pkg::TEX_W-1:0]           texture_id;
  logic signed [ssb_pkg::DEPTH_W-1:0]  depth_key;
  logic                                is_last;

  modport source (output valid, texture_id, depth_key, is_last, input ready);
  modport sink   (input valid, texture_id, depth_key, is_last, output ready);
endinterface

interface ssb_result_if;
  logic                      valid;
  logic                      ready;
  logic [ssb_pkg::SRC_W-1:0] source_index;
  logic [ssb_pkg::TEX_W-1:0] texture_out;
  logic                      starts_run;
  logic                      ends_run;
  logic [ssb_pkg::OFS_W-1:0] run_offset;
  logic [ssb_pkg::OFS_W-1:0] run_vertices;
  logic                      overflow;
  logic                      last_out;

  modport source (output valid, source_index, texture_out, starts_run, ends_run,
                  run_offset, run_vertices, overflow, last_out, input ready);
  modport sink   (input valid, source_index, texture_out, starts_run, ends_run,
                  run_offset, run_vertices, overflow, last_out, output ready);
endinterface

interface ssb_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [ssb_pkg::MODE_W-1:0] sort_mode;

  modport source (output valid, sort_mode, input ready);
  modport sink   (input valid, sort_mode, output ready);
endinterface

@@ src/sprite_sort_and_batch.sv @@
// Channel    Dir  Handshake      Payload
// sprite_i   in   valid/ready    texture_id, depth_key, is_last
// result_o   out  valid/ready    source_index, texture_out, starts_run, ends_run,
//                                run_offset, run_vertices, overflow, last_out
// cfg_i      in   valid/ready    sort_mode (ready always high)
//
// Sprites load one per cycle while the block is in its load state. Closing a batch
// of n sprites ranks every entry against all others through the single entry-memory
// read port, then fetches each result through the order memory.
// Reset empties the batch and sets sort_mode to texture ascending.
// A stalled result holds in the output register; fetching of the next one goes
// on meanwhile, and the next batch may start loading while the final item waits.
module sprite_sort_and_batch (
  input  logic         clk_i,
  input  logic         rst_ni,
  ssb_sprite_if.sink   sprite_i,
  ssb_result_if.source result_o,
  ssb_cfg_if.sink      cfg_i
);
  import ssb_pkg::*;

  ssb_cmd_t    cmd;
  ssb_status_t status;
  logic        in_ready;
  logic        out_valid;
  out_item_t   out_item;

  ssb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (sprite_i.valid),
    .in_last_i  (sprite_i.is_last),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ssb_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_i.valid),
    .cfg_mode_i   (cfg_i.sort_mode),
    .texture_id_i (sprite_i.texture_id),
    .depth_key_i  (sprite_i.depth_key),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_ready_i  (result_o.ready),
    .out_valid_o  (out_valid),
    .out_item_o   (out_item)
  );

  assign sprite_i.ready        = in_ready;
  assign cfg_i.ready           = 1'b1;
  assign result_o.valid        = out_valid;
  assign result_o.source_index = out_item.source_index;
  assign result_o.texture_out  = out_item.texture_out;
  assign result_o.starts_run   = out_item.starts_run;
  assign result_o.ends_run     = out_item.ends_run;
  assign result_o.run_offset   = out_item.run_offset;
  assign result_o.run_vertices = out_item.run_vertices;
  assign result_o.overflow     = out_item.overflow;
  assign result_o.last_out     = out_item.last_out;

endmodule

@@ src/ssb_ctrl.sv @@
module ssb_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_last_i,
  output logic                 in_ready_o,
  input  ssb_pkg::ssb_status_t status_i,
  output ssb_pkg::ssb_cmd_t    cmd_o
);
  import ssb_pkg::*;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_RK_FETCH,
    ST_RK_LATCH,
    ST_RK_SCAN,
    ST_OUT_INIT,
    ST_FT_ORD,
    ST_FT_DAT,
    ST_FT_LATCH,
    ST_EMIT
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_LOAD: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.store = 1'b1;
          if (in_last_i) begin
            state_d = ST_RK_FETCH;
          end
        end
      end
      ST_RK_FETCH: begin
        cmd_o.rank_fetch = 1'b1;
        state_d          = ST_RK_LATCH;
      end
      ST_RK_LATCH: begin
        cmd_o.rank_start = 1'b1;
        state_d          = ST_RK_SCAN;
      end
      ST_RK_SCAN: begin
        cmd_o.rank_step = 1'b1;
        if (status_i.j_last) begin
          state_d = status_i.i_last ? ST_OUT_INIT : ST_RK_FETCH;
        end
      end
      ST_OUT_INIT: begin
        cmd_o.out_init = 1'b1;
        state_d        = ST_FT_ORD;
      end
      ST_FT_ORD: begin
        cmd_o.ord_rd = 1'b1;
        state_d      = ST_FT_DAT;
      end
      ST_FT_DAT: begin
        cmd_o.dat_rd = 1'b1;
        state_d      = ST_FT_LATCH;
      end
      ST_FT_LATCH: begin
        cmd_o.latch = 1'b1;
        // first fetch fills the current slot, then look one ahead
        if (status_i.cur_empty && status_i.more_after) begin
          state_d = ST_FT_ORD;
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (status_i.k_last) begin
            cmd_o.clr_batch = 1'b1;
            state_d         = ST_LOAD;
          end else if (status_i.more_fetch) begin
            state_d = ST_FT_ORD;
          end
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ src/ssb_dpath.sv @@
module ssb_dpath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  input  logic [ssb_pkg::MODE_W-1:0]          cfg_mode_i,
  input  logic [ssb_pkg::TEX_W-1:0]           texture_id_i,
  input  logic signed [ssb_pkg::DEPTH_W-1:0]  depth_key_i,
  input  ssb_pkg::ssb_cmd_t                   cmd_i,
  output ssb_pkg::ssb_status_t                status_o,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output ssb_pkg::out_item_t                  out_item_o
);
  import ssb_pkg::*;

  entry_t             mem_q [MAX_SPRITES];
  logic [IDX_W-1:0]   ord_mem_q [MAX_SPRITES];

  sort_mode_e         mode_q;
  logic [CNT_W-1:0]   count_q;
  logic               drop_q;
  logic [IDX_W-1:0]   i_q, j_q, rank_q, k_q, run_start_q;
  logic [CNT_W-1:0]   f_q;
  logic [TEX_W-1:0]   key_i_q;
  entry_t             rdata_q;
  logic [IDX_W-1:0]   ord_rdata_q;
  logic [TEX_W-1:0]   cur_tex_q, nxt_tex_q, prev_tex_q;
  logic [IDX_W-1:0]   cur_idx_q, nxt_idx_q;
  logic               out_valid_q;
  out_item_t          out_q;

  logic               full;
  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  logic [TEX_W-1:0]   key_j;
  logic               prec;
  logic [IDX_W-1:0]   rank_nx;
  logic [CNT_W-1:0]   last_pos;
  logic               starts, ends;
  logic [IDX_W-1:0]   rs;
  logic [CNT_W-1:0]   run_len;
  logic               out_free;

  assign full     = (count_q == CNT_W'(MAX_SPRITES));
  assign last_pos = count_q - 1'b1;

  always_comb begin
    rd_en   = 1'b1;
    rd_addr = i_q;
    if (cmd_i.rank_start) begin
      rd_addr = '0;
    end else if (cmd_i.rank_step) begin
      rd_addr = j_q + 1'b1;
    end else if (cmd_i.dat_rd) begin
      rd_addr = ord_rdata_q;
    end else if (!cmd_i.rank_fetch) begin
      rd_en = 1'b0;
    end
  end

  // j goes before i: smaller key, or equal key and earlier arrival
  assign key_j   = sort_key(mode_q, rdata_q.tex, rdata_q.depth);
  assign prec    = (key_j < key_i_q) || ((key_j == key_i_q) && (j_q < i_q));
  assign rank_nx = rank_q + IDX_W'(prec);

  assign starts  = (k_q == '0) || (prev_tex_q != cur_tex_q);
  assign ends    = status_o.k_last || (nxt_tex_q != cur_tex_q);
  assign rs      = starts ? k_q : run_start_q;
  assign run_len = CNT_W'(k_q - rs) + 1'b1;
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    status_o            = '0;
    status_o.j_last     = (CNT_W'(j_q) == last_pos);
    status_o.i_last     = (CNT_W'(i_q) == last_pos);
    status_o.cur_empty  = (f_q == '0);
    status_o.more_after = (CNT_W'(f_q + 1'b1) < count_q);
    status_o.more_fetch = (f_q < count_q);
    status_o.k_last     = (CNT_W'(k_q) == last_pos);
    status_o.out_free   = out_free;
  end

  // storage, no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.store && !full) begin
      mem_q[count_q[IDX_W-1:0]] <= '{tex: texture_id_i, depth: $unsigned(depth_key_i)};
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rank_step && status_o.j_last) begin
      ord_mem_q[rank_nx] <= i_q;
    end
    if (cmd_i.ord_rd) begin
      ord_rdata_q <= ord_mem_q[f_q[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rank_start) begin
      key_i_q <= sort_key(mode_q, rdata_q.tex, rdata_q.depth);
    end
    if (cmd_i.latch) begin
      if (f_q == '0) begin
        cur_tex_q <= rdata_q.tex;
        cur_idx_q <= ord_rdata_q;
      end else begin
        nxt_tex_q <= rdata_q.tex;
        nxt_idx_q <= ord_rdata_q;
      end
    end
    if (cmd_i.emit) begin
      prev_tex_q              <= cur_tex_q;
      cur_tex_q               <= nxt_tex_q;
      cur_idx_q               <= nxt_idx_q;
      out_q.source_index      <= SRC_W'(cur_idx_q);
      out_q.texture_out       <= cur_tex_q;
      out_q.starts_run        <= starts;
      out_q.ends_run          <= ends;
      out_q.run_offset        <= vert_count(CNT_W'(rs));
      out_q.run_vertices      <= ends ? vert_count(run_len) : '0;
      out_q.overflow          <= drop_q;
      out_q.last_out          <= status_o.k_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_TEX_UP;
      count_q     <= '0;
      drop_q      <= 1'b0;
      i_q         <= '0;
      j_q         <= '0;
      rank_q      <= '0;
      k_q         <= '0;
      f_q         <= '0;
      run_start_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        mode_q <= sort_mode_e'(cfg_mode_i);
      end
      if (cmd_i.store) begin
        if (full) begin
          drop_q <= 1'b1;
        end else begin
          count_q <= count_q + 1'b1;
        end
      end
      if (cmd_i.rank_start) begin
        j_q    <= '0;
        rank_q <= '0;
      end
      if (cmd_i.rank_step) begin
        j_q    <= j_q + 1'b1;
        rank_q <= rank_nx;
        if (status_o.j_last) begin
          i_q <= i_q + 1'b1;
        end
      end
      if (cmd_i.out_init) begin
        k_q <= '0;
        f_q <= '0;
      end
      if (cmd_i.latch) begin
        f_q <= f_q + 1'b1;
      end
      if (cmd_i.emit) begin
        k_q         <= k_q + 1'b1;
        run_start_q <= rs;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.clr_batch) begin
        count_q <= '0;
        drop_q  <= 1'b0;
        i_q     <= '0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule
